// ===== design/range_limited_mt64_variant_rng_unit_macros.svh =====
// Assertion macros shared by the checker of the range-limited generator.
`ifndef RANGE_LIMITED_MT64_VARIANT_RNG_UNIT_MACROS_SVH
`define RANGE_LIMITED_MT64_VARIANT_RNG_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rlm_pkg.sv =====
// Package with types, constants and word functions of the range-limited generator.
package rlm_pkg;

  localparam int unsigned StoreWords = 624;
  localparam int unsigned HalfWords  = 312;

  localparam logic [63:0] SeedMult    = 64'd6364136223846793005;
  localparam logic [63:0] UpperMask   = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] LowerMask   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] MixConst    = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] PastEndWord = 64'h5555_5555_5555_5555;
  localparam logic [63:0] TemperB     = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [63:0] TemperC     = 64'hFFF7_EEE0_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED0,
    ST_MUL,
    ST_CLEAR,
    ST_RANGE,
    ST_LIMIT,
    ST_DRAW,
    ST_REFILL,
    ST_READ,
    ST_TEMPER,
    ST_DIVGO,
    ST_DIV,
    ST_DONE
  } state_e;

  function automatic logic [63:0] mix_pair(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] z;
    begin
      z = (a & UpperMask) | (b & LowerMask);
      mix_pair = (z >> 1) ^ (z[0] ? MixConst : 64'd0);
    end
  endfunction

  function automatic logic [63:0] temper(input logic [63:0] w);
    logic [63:0] x;
    begin
      x = w;
      x = x ^ ((x >> 29) & PastEndWord);
      x = x ^ ((x << 17) & TemperB);
      x = x ^ ((x << 37) & TemperC);
      temper = x ^ (x >> 43);
    end
  endfunction

endpackage

// ===== design/range_limited_mt64_variant_rng_unit.sv =====
// Each draw takes one serial division; each request with a range above one adds one more for the limit.
// A pending seed adds a store initialization before the first draw.
// Refills rewrite 312 words each, once per 312 draws.
// One request at a time; reset clears control state, seed is 0 and initialization pends.
module range_limited_mt64_variant_rng_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [63:0] seed_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] low_i,
  input  logic [31:0] high_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_o
);

  localparam logic [9:0] LastWord = 10'(rlm_pkg::StoreWords - 1);
  localparam logic [9:0] HalfIdx  = 10'(rlm_pkg::HalfWords);
  localparam logic [9:0] EndIdx   = 10'(rlm_pkg::StoreWords);

  rlm_pkg::state_e state_q, state_d;

  logic [63:0] seed_q, seed_d;
  logic        pend_q, pend_d;
  logic [9:0]  idx_q, idx_d;
  logic [9:0]  cnt_q, cnt_d;
  logic [2:0]  sub_q, sub_d;
  logic        full_q, full_d;
  logic        outv_q, outv_d;
  logic [31:0] value_q, value_d;
  logic [31:0] low_q, low_d;
  logic [31:0] range_q, range_d;
  logic [31:0] res_q, res_d;
  logic [63:0] w_q, w_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] thr_q, thr_d;
  logic [63:0] d_q, d_d;
  logic [63:0] x_q, x_d;
  logic [63:0] a_q, a_d;

  logic [63:0] mem [rlm_pkg::StoreWords];
  logic [63:0] rd_q;
  logic        past_q;
  logic        mem_we, mem_re;
  logic [9:0]  mem_wa, mem_ra;
  logic [63:0] mem_wd;
  logic [63:0] rdv;

  logic [31:0] mul_a, mul_b;
  logic [63:0] tw;
  logic [9:0]  ref_x, ref_a, ref_b, ref_w;

  logic        div_start, div_done;
  logic [63:0] div_dvd;
  logic [31:0] div_rem;

  rlm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .dvd_i  (div_dvd),
    .dvs_i  (range_q),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

  // Words past the end of the store read as a fixed pattern during the full refill.
  assign rdv = past_q ? rlm_pkg::PastEndWord : rd_q;
  assign tw  = w_q ^ (w_q >> 62);

  // Operand addresses of one refill step.
  always_comb begin
    if (!full_q) begin
      ref_x = cnt_q + 10'd155;
      ref_a = cnt_q - 10'd1;
      ref_b = cnt_q;
      ref_w = cnt_q + 10'd311;
    end else if (cnt_q == HalfIdx) begin
      ref_x = 10'd155;
      ref_a = LastWord;
      ref_b = 10'd0;
      ref_w = 10'd311;
    end else begin
      ref_x = (cnt_q <= 10'd156) ? cnt_q + 10'd468 : cnt_q - 10'd156;
      ref_a = cnt_q + 10'd312;
      ref_b = cnt_q + 10'd313;
      ref_w = cnt_q;
    end
  end

  always_comb begin
    case (sub_q)
      3'd1:    begin mul_a = tw[31:0];  mul_b = rlm_pkg::SeedMult[63:32]; end
      3'd2:    begin mul_a = tw[63:32]; mul_b = rlm_pkg::SeedMult[31:0];  end
      default: begin mul_a = tw[31:0];  mul_b = rlm_pkg::SeedMult[31:0];  end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    seed_d    = seed_q;
    pend_d    = pend_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    sub_d     = sub_q;
    full_d    = full_q;
    outv_d    = outv_q;
    value_d   = value_q;
    low_d     = low_q;
    range_d   = range_q;
    res_d     = res_q;
    w_d       = w_q;
    acc_d     = acc_q;
    prod_d    = prod_q;
    thr_d     = thr_q;
    d_d       = d_q;
    x_d       = x_q;
    a_d       = a_q;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = '0;
    div_start = 1'b0;
    div_dvd   = d_q;
    in_ready_o = (state_q == rlm_pkg::ST_IDLE);

    if (outv_q && out_ready_i) begin
      outv_d = 1'b0;
    end
    if (seed_we_i) begin
      seed_d = seed_i;
      pend_d = 1'b1;
    end

    case (state_q)
      rlm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          low_d   = low_i;
          range_d = high_i - low_i + 32'd1;
          state_d = pend_q ? rlm_pkg::ST_SEED0 : rlm_pkg::ST_RANGE;
        end
      end
      rlm_pkg::ST_SEED0: begin
        mem_we  = 1'b1;
        mem_wa  = '0;
        mem_wd  = seed_q;
        w_d     = seed_q;
        cnt_d   = 10'd1;
        sub_d   = '0;
        state_d = rlm_pkg::ST_MUL;
      end
      rlm_pkg::ST_MUL: begin
        // The 64-bit product is built from three 32-bit partial products.
        sub_d = sub_q + 3'd1;
        case (sub_q)
          3'd0: prod_d = mul_a * mul_b;
          3'd1: begin
            acc_d  = prod_q + {54'd0, cnt_q};
            prod_d = mul_a * mul_b;
          end
          3'd2: begin
            acc_d  = acc_q + {prod_q[31:0], 32'd0};
            prod_d = mul_a * mul_b;
          end
          3'd3: acc_d = acc_q + {prod_q[31:0], 32'd0};
          default: begin
            mem_we = 1'b1;
            mem_wa = cnt_q;
            mem_wd = acc_q;
            w_d    = acc_q;
            sub_d  = '0;
            cnt_d  = cnt_q + 10'd1;
            if (cnt_q == HalfIdx) begin
              state_d = rlm_pkg::ST_CLEAR;
            end
          end
        endcase
      end
      rlm_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt_q;
        mem_wd = '0;
        cnt_d  = cnt_q + 10'd1;
        if (cnt_q == LastWord) begin
          idx_d   = HalfIdx;
          pend_d  = seed_we_i;
          state_d = rlm_pkg::ST_RANGE;
        end
      end
      rlm_pkg::ST_RANGE: begin
        if (range_q <= 32'd1) begin
          res_d   = low_q;
          state_d = rlm_pkg::ST_DONE;
        end else begin
          div_start = 1'b1;
          div_dvd   = '1;
          state_d   = rlm_pkg::ST_LIMIT;
        end
      end
      rlm_pkg::ST_LIMIT: begin
        // A draw is kept when it lies below the largest multiple of the range.
        if (div_done) begin
          thr_d   = 64'hFFFF_FFFF_FFFF_FFFF - {32'd0, div_rem};
          state_d = rlm_pkg::ST_DRAW;
        end
      end
      rlm_pkg::ST_DRAW: begin
        cnt_d = 10'd1;
        sub_d = '0;
        if (idx_q == HalfIdx) begin
          full_d  = 1'b0;
          state_d = rlm_pkg::ST_REFILL;
        end else if (idx_q >= EndIdx) begin
          full_d  = 1'b1;
          state_d = rlm_pkg::ST_REFILL;
        end else begin
          state_d = rlm_pkg::ST_READ;
        end
      end
      rlm_pkg::ST_REFILL: begin
        sub_d = sub_q + 3'd1;
        case (sub_q)
          3'd0: begin
            mem_re = 1'b1;
            mem_ra = ref_x;
          end
          3'd1: begin
            x_d    = rdv;
            mem_re = 1'b1;
            mem_ra = ref_a;
          end
          3'd2: begin
            a_d    = rdv;
            mem_re = 1'b1;
            mem_ra = ref_b;
          end
          default: begin
            mem_we = 1'b1;
            mem_wa = ref_w;
            mem_wd = x_q ^ rlm_pkg::mix_pair(a_q, rdv);
            sub_d  = '0;
            cnt_d  = cnt_q + 10'd1;
            if (cnt_q == HalfIdx) begin
              if (full_q) begin
                idx_d = '0;
              end
              state_d = rlm_pkg::ST_READ;
            end
          end
        endcase
      end
      rlm_pkg::ST_READ: begin
        mem_re  = 1'b1;
        mem_ra  = idx_q;
        state_d = rlm_pkg::ST_TEMPER;
      end
      rlm_pkg::ST_TEMPER: begin
        d_d     = rlm_pkg::temper(rdv);
        idx_d   = idx_q + 10'd1;
        state_d = rlm_pkg::ST_DIVGO;
      end
      rlm_pkg::ST_DIVGO: begin
        div_start = 1'b1;
        state_d   = rlm_pkg::ST_DIV;
      end
      rlm_pkg::ST_DIV: begin
        if (div_done) begin
          if (d_q < thr_q) begin
            res_d   = low_q + div_rem;
            state_d = rlm_pkg::ST_DONE;
          end else begin
            state_d = rlm_pkg::ST_DRAW;
          end
        end
      end
      rlm_pkg::ST_DONE: begin
        if (!outv_q || out_ready_i) begin
          outv_d  = 1'b1;
          value_d = res_q;
          state_d = rlm_pkg::ST_IDLE;
        end
      end
      default: state_d = rlm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rlm_pkg::ST_IDLE;
      seed_q  <= '0;
      pend_q  <= 1'b1;
      idx_q   <= HalfIdx;
      cnt_q   <= '0;
      sub_q   <= '0;
      full_q  <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      seed_q  <= seed_d;
      pend_q  <= pend_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      sub_q   <= sub_d;
      full_q  <= full_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    low_q   <= low_d;
    range_q <= range_d;
    res_q   <= res_d;
    w_q     <= w_d;
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    thr_q   <= thr_d;
    d_q     <= d_d;
    x_q     <= x_d;
    a_q     <= a_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      past_q <= (mem_ra >= EndIdx);
      if (mem_ra < EndIdx) begin
        rd_q <= mem[mem_ra];
      end
    end
  end

  assign out_valid_o = outv_q;
  assign value_o     = value_q;

endmodule

// ===== design/rlm_div.sv =====
// Bit-serial restoring divider that returns the remainder of a 64-bit word by a 32-bit divisor.
module rlm_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dvd_i,
  input  logic [31:0] dvs_i,
  output logic        done_o,
  output logic [31:0] rem_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] dvd_q, dvd_d;
  logic [31:0] dvs_q, dvs_d;
  logic [31:0] rem_q, rem_d;
  logic [32:0] trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[63]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dvd_i;
      dvs_d  = dvs_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        trial = trial - {1'b0, dvs_q};
      end
      rem_d = trial[31:0];
      dvd_d = {dvd_q[62:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/rlm_checker.sv =====
// Port-level checker of the range-limited generator and its bind to the top level.
`include "range_limited_mt64_variant_rng_unit_macros.svh"

module rlm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        seed_we_i,
  input logic [63:0] seed_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [31:0] low_i,
  input logic [31:0] high_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] value_o
);

  `RLM_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `RLM_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable(value_o), "result changed")
  `RLM_ASSERT_NXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o, "request overlap")
  `RLM_ASSERT_IMP(a_result_from_work, $rose(out_valid_o), $past(!in_ready_o), "stray result")

endmodule

bind range_limited_mt64_variant_rng_unit rlm_checker u_rlm_checker (.*);

// ===== sim/tb_range_limited_mt64_variant_rng_unit.sv =====
// Testbench of the range-limited generator: directed rows, random requests, own predictor.
`timescale 1ns / 1ps

module tb_range_limited_mt64_variant_rng_unit;

  localparam int unsigned WatchLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        seed_we_i = 1'b0;
  logic [63:0] seed_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] low_i = '0;
  logic [31:0] high_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] value_o;

  range_limited_mt64_variant_rng_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .seed_we_i(seed_we_i), .seed_i(seed_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .low_i(low_i), .high_i(high_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .value_o(value_o)
  );

  always #5 clk_i = ~clk_i;

  // Generator copy kept by the testbench.
  logic [63:0] gen_seed;
  logic [63:0] gen_words[rlm_pkg::StoreWords];
  int unsigned gen_pos;
  bit          gen_reseed;

  function automatic logic [63:0] pair_mix(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] z;
    z = (a & 64'hFFFF_FFFF_8000_0000) | (b & 64'h0000_0000_7FFF_FFFF);
    return (z >> 1) ^ (z[0] ? 64'hB502_6F5A_A966_19E9 : 64'd0);
  endfunction

  function automatic logic [63:0] word_or_pad(input int unsigned k);
    return (k < rlm_pkg::StoreWords) ? gen_words[k] : 64'h5555_5555_5555_5555;
  endfunction

  function automatic void seed_words();
    logic [63:0] w;
    w = gen_seed;
    gen_words[0] = w;
    for (int unsigned i = 1; i <= rlm_pkg::HalfWords; i++) begin
      w = (w ^ (w >> 62)) * 64'd6364136223846793005 + 64'(i);
      gen_words[i] = w;
    end
    for (int unsigned i = rlm_pkg::HalfWords + 1; i < rlm_pkg::StoreWords; i++)
      gen_words[i] = '0;
    gen_pos = rlm_pkg::HalfWords;
    gen_reseed = 1'b0;
  endfunction

  function automatic logic [63:0] next_draw();
    logic [63:0] x;
    if (gen_pos == rlm_pkg::HalfWords) begin
      for (int unsigned i = 1; i <= rlm_pkg::HalfWords; i++)
        gen_words[i + 311] = gen_words[i + 155] ^ pair_mix(gen_words[i - 1], gen_words[i]);
    end else if (gen_pos >= rlm_pkg::StoreWords) begin
      // The full refill reads past the end of the store on purpose.
      for (int unsigned k = 1; k <= 156; k++)
        gen_words[k] = word_or_pad(k + 468) ^ pair_mix(gen_words[k + 312], word_or_pad(k + 313));
      for (int unsigned k = 157; k <= 311; k++)
        gen_words[k] = gen_words[k - 156] ^ pair_mix(gen_words[k + 312], word_or_pad(k + 313));
      gen_words[311] = gen_words[155] ^ pair_mix(gen_words[623], gen_words[0]);
      gen_pos = 0;
    end
    x = gen_words[gen_pos];
    gen_pos++;
    x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
    x = x ^ ((x << 17) & 64'h71D6_7FFF_EDA6_0000);
    x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
    return x ^ (x >> 43);
  endfunction

  function automatic logic [31:0] ranged_value(input logic [31:0] lo, input logic [31:0] hi);
    logic [31:0] span;
    logic [63:0] lim, d;
    span = hi - lo + 32'd1;
    if (gen_reseed) seed_words();
    if (span <= 32'd1) return lo;
    lim = 64'hFFFF_FFFF_FFFF_FFFF / {32'd0, span};
    forever begin
      d = next_draw();
      if (d / {32'd0, span} < lim) break;
    end
    return lo + 32'(d % {32'd0, span});
  endfunction

  // Directed rows; fixed marks the ones whose answer is plain.
  typedef struct {
    logic [31:0] lo;
    logic [31:0] hi;
    bit          fixed;
    logic [31:0] want;
  } row_t;

  row_t rows[] = '{
    '{32'd0, 32'd0, 1, 32'd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF},
    '{32'd0, 32'hFFFF_FFFF, 1, 32'd0},
    '{32'd5, 32'd4, 1, 32'd5},
    '{32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h8000_0000},
    '{32'h1234_5678, 32'h1234_5678, 1, 32'h1234_5678},
    '{32'd0, 32'd1, 0, 32'd0},
    '{32'd0, 32'hFFFF_FFFE, 0, 32'd0},
    '{32'd1, 32'hFFFF_FFFF, 0, 32'd0},
    '{32'hFFFF_FFF0, 32'd16, 0, 32'd0},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 0, 32'd0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 0, 32'd0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 0, 32'd0},
    '{32'd100, 32'd109, 0, 32'd0}
  };

  logic [31:0] value_due[$];
  bit          cur_fixed = 0;
  logic [31:0] cur_want = '0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned requests = 0;
  int unsigned checked = 0;
  int unsigned quiet = 0;

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    logic [31:0] exp_v, pred;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (in_valid_i && in_ready_o) begin
        pred = ranged_value(low_i, high_i);
        value_due.push_back(cur_fixed ? cur_want : pred);
        requests <= requests + 1;
      end
      if (out_valid_o && out_ready_i) begin
        checked <= checked + 1;
        if (value_due.size() == 0) begin
          $error("value: result 0x%08h with no request outstanding", value_o);
          errors <= errors + 1;
        end else begin
          exp_v = value_due.pop_front();
          if (exp_v !== value_o) begin
            $error("value: expected 0x%08h, got 0x%08h", exp_v, value_o);
            errors <= errors + 1;
          end
        end
      end
      if (quiet >= WatchLimit) begin
        $display("watchdog expired with %0d results outstanding", value_due.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send(input logic [31:0] lo, input logic [31:0] hi, input bit fx,
                      input logic [31:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    low_i <= lo;
    high_i <= hi;
    cur_fixed <= fx;
    cur_want <= want;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    logic [31:0] lo, hi;
    lo = $urandom;
    case ($urandom_range(9))
      0: hi = lo;
      1: hi = lo - 32'd1;
      2: hi = lo + 32'($urandom_range(1, 15));
      3: begin
        lo = $urandom_range(0, 15);
        hi = 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
      end
      default: hi = $urandom;
    endcase
    send(lo, hi, 0, '0);
  endtask

  task automatic drain_queue();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (value_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_seed(input logic [63:0] s);
    seed_we_i <= 1'b1;
    seed_i <= s;
    gen_seed = s;
    gen_reseed = 1'b1;
    @(negedge clk_i);
    seed_we_i <= 1'b0;
  endtask

  initial begin
    logic [63:0] seeds[4];
    int unsigned idle_set[4][2];
    seeds = '{64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom}, 64'd0, {$urandom, $urandom}};
    idle_set = '{'{69, 0}, '{0, 69}, '{13, 13}, '{0, 0}};
    gen_seed = '0;
    seed_words();
    gen_reseed = 1'b1;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send(rows[i].lo, rows[i].hi, rows[i].fixed, rows[i].want);
    repeat (380) send_random();

    for (int p = 0; p < 4; p++) begin
      drain_queue();
      send_idle_pct = idle_set[p][0];
      recv_stall_pct = idle_set[p][1];
      write_seed(seeds[p]);
      for (int n = 0; n < 290; n++) begin
        // Hold the next request back until everything in flight has come out.
        if (p == 1 && n == 150) drain_queue();
        send_random();
      end
    end
    drain_queue();
    repeat (300) @(negedge clk_i);

    $display("Ran %0d requests, checked %0d results over five seeds and four idle mixes.",
             requests, checked);
    if (errors == 0 && value_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/rlm_pkg.sv
design/rlm_div.sv
design/range_limited_mt64_variant_rng_unit.sv
design/rlm_checker.sv
sim/tb_range_limited_mt64_variant_rng_unit.sv
